@@ src/chained_hash_table_defines.svh @@
// Assertion macros for the chained hash table.
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define CHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define CHT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition");
`else
`define CHT_ASSERT(lbl, prop)
`define CHT_NEVER(lbl, cond)
`endif
`endif

@@ src/cht_pkg.sv @@
// Shared types and constants of the chained hash table.
package cht_pkg;
  localparam int unsigned DefBuckets = 256;
  localparam int unsigned DefEntries = 512;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned ValW       = 32;
  localparam int unsigned CountW     = 10;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HEAD, ST_WALK, ST_DECIDE,
    ST_ALLOC, ST_LINK, ST_UNLINK, ST_RESP
  } state_e;
endpackage

@@ src/chained_hash_table.sv @@
// Chained hash table: top level with bucket-head and entry memories.
// Each transaction reads the bucket head, walks the chain (one entry memory read per cycle)
// and decides; a new insert then allocates and links an entry, a found remove frees its entry.
// Throughput: one transaction at a time; the next is taken in the cycle after the result is
// loaded into the output register.
// Reset: after rst_ni releases, a clearing pass of BUCKETS cycles nulls the bucket heads.
`include "chained_hash_table_defines.svh"
module chained_hash_table import cht_pkg::*; #(
  parameter int unsigned BUCKETS = DefBuckets,
  parameter int unsigned ENTRIES = DefEntries
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [KeyW-1:0]   key_i,
  input  logic [ValW-1:0]   value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              found_o,
  output logic [ValW-1:0]   data_o,
  output logic              status_o,
  output logic [CountW-1:0] count_o
);
  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned EW = $clog2(ENTRIES);
  localparam int unsigned LW = $clog2(ENTRIES + 1);
  localparam int unsigned WW = KeyW + ValW + LW;
  localparam logic [LW-1:0] Nil = LW'(ENTRIES);
  localparam logic [BW-1:0] LastBucket = BW'(BUCKETS - 1);
  localparam logic [LW-1:0] MaxSteps = LW'(ENTRIES);

  state_e state_q, state_d;

  logic [1:0]      op_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;
  logic [LW-1:0]   cur_q, cur_d, prev_q, prev_d, steps_q, steps_d;
  logic [WW-1:0]   hit_w_q, hit_w_d, prev_w_q, prev_w_d;
  logic            found_q, found_d;
  logic [LW-1:0]   free_q, free_d, fresh_q, fresh_d, count_q, count_d;
  logic [LW-1:0]   alloc_q, alloc_d;
  logic [BW-1:0]   clr_q, clr_d;
  logic            r_found_q, r_found_d, r_status_q, r_status_d;
  logic [ValW-1:0] r_data_q, r_data_d;
  logic            ov_q, ov_d, of_q, os_q;
  logic [ValW-1:0] od_q;
  logic [LW-1:0]   oc_q;

  logic            h_we;
  logic [BW-1:0]   h_waddr, h_raddr;
  logic [LW-1:0]   h_wdata, h_rdata;
  logic            e_we;
  logic [EW-1:0]   e_waddr, e_raddr;
  logic [WW-1:0]   e_wdata, e_rdata;

  logic [KeyW-1:0] rd_key;
  logic [LW-1:0]   rd_link, steps_n;
  logic            in_acc, out_load;

  assign rd_key  = e_rdata[WW-1 -: KeyW];
  assign rd_link = e_rdata[LW-1:0];
  assign steps_n = steps_q + LW'(1);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_load = (state_q == ST_RESP) && (!ov_q || out_ready_i);

  cht_ram #(.Width(LW), .Depth(BUCKETS)) u_head_ram (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  cht_ram #(.Width(WW), .Depth(ENTRIES)) u_entry_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == LastBucket) state_d = ST_IDLE;
      ST_IDLE:  if (in_acc) state_d = ST_HEAD;
      ST_HEAD:  state_d = (h_rdata == Nil) ? ST_DECIDE : ST_WALK;
      ST_WALK: begin
        if (rd_key == key_q || rd_link == Nil || steps_n == MaxSteps) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (op_q == OP_INSERT && !found_q && free_q != Nil) state_d = ST_ALLOC;
        else if (op_q == OP_REMOVE && found_q) state_d = ST_UNLINK;
        else state_d = ST_RESP;
      end
      ST_ALLOC:  state_d = (prev_q == Nil) ? ST_RESP : ST_LINK;
      ST_LINK:   state_d = ST_RESP;
      ST_UNLINK: state_d = ST_RESP;
      ST_RESP:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cur_d = cur_q; prev_d = prev_q; steps_d = steps_q;
    hit_w_d = hit_w_q; prev_w_d = prev_w_q; found_d = found_q;
    free_d = free_q; fresh_d = fresh_q; count_d = count_q; alloc_d = alloc_q;
    clr_d = clr_q;
    r_found_d = r_found_q; r_status_d = r_status_q; r_data_d = r_data_q;
    h_we = 1'b0; h_waddr = key_q[BW-1:0]; h_wdata = Nil;
    h_raddr = key_i[BW-1:0];
    e_we = 1'b0; e_waddr = cur_q[EW-1:0]; e_wdata = '0;
    e_raddr = cur_q[EW-1:0];
    case (state_q)
      ST_CLEAR: begin
        h_we = 1'b1; h_waddr = clr_q; h_wdata = Nil;
        clr_d = clr_q + BW'(1);
      end
      ST_HEAD: begin
        prev_d = Nil; steps_d = '0; found_d = 1'b0;
        cur_d = h_rdata; e_raddr = h_rdata[EW-1:0];
      end
      ST_WALK: begin
        if (rd_key == key_q) begin
          found_d = 1'b1; hit_w_d = e_rdata;
        end else begin
          prev_d = cur_q; prev_w_d = e_rdata; steps_d = steps_n;
          cur_d = rd_link; e_raddr = rd_link[EW-1:0];
        end
      end
      ST_DECIDE: begin
        r_found_d = found_q; r_status_d = 1'b0; r_data_d = '0;
        e_raddr = free_q[EW-1:0];
        case (op_q)
          OP_INSERT: begin
            r_data_d = val_q;
            if (found_q) begin
              e_we = 1'b1; e_waddr = cur_q[EW-1:0];
              e_wdata = {key_q, val_q, hit_w_q[LW-1:0]};
            end else if (free_q == Nil) begin
              r_status_d = 1'b1; r_data_d = '0;
            end
          end
          OP_REMOVE: begin
            if (found_q) begin
              if (prev_q == Nil) begin
                h_we = 1'b1; h_wdata = hit_w_q[LW-1:0];
              end else begin
                e_we = 1'b1; e_waddr = prev_q[EW-1:0];
                e_wdata = {prev_w_q[WW-1:LW], hit_w_q[LW-1:0]};
              end
            end
          end
          default: begin
            if (found_q) r_data_d = hit_w_q[LW +: ValW];
          end
        endcase
      end
      ST_ALLOC: begin
        // entries at or above fresh_q have never been used and chain in order
        if (free_q == fresh_q) begin
          fresh_d = fresh_q + LW'(1);
          free_d = fresh_q + LW'(1);
        end else begin
          free_d = rd_link;
        end
        alloc_d = free_q;
        count_d = count_q + LW'(1);
        e_we = 1'b1; e_waddr = free_q[EW-1:0]; e_wdata = {key_q, val_q, Nil};
        if (prev_q == Nil) begin
          h_we = 1'b1; h_wdata = free_q;
        end
      end
      ST_LINK: begin
        e_we = 1'b1; e_waddr = prev_q[EW-1:0];
        e_wdata = {prev_w_q[WW-1:LW], alloc_q};
      end
      ST_UNLINK: begin
        e_we = 1'b1; e_waddr = cur_q[EW-1:0];
        e_wdata = {hit_w_q[WW-1:LW], free_q};
        free_d = cur_q;
        count_d = count_q - LW'(1);
      end
      default: ;
    endcase
  end

  assign ov_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      free_q  <= '0;
      fresh_q <= '0;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      free_q  <= free_d;
      fresh_q <= fresh_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    cur_q <= cur_d; prev_q <= prev_d; steps_q <= steps_d;
    hit_w_q <= hit_w_d; prev_w_q <= prev_w_d; found_q <= found_d;
    alloc_q <= alloc_d;
    r_found_q <= r_found_d; r_status_q <= r_status_d; r_data_q <= r_data_d;
    if (out_load) begin
      of_q <= r_found_q;
      os_q <= r_status_q;
      od_q <= r_data_q;
      oc_q <= count_q;
    end
  end

  assign out_valid_o = ov_q;
  assign found_o     = of_q;
  assign status_o    = os_q;
  assign data_o      = od_q;
  assign count_o     = CountW'(oc_q);

  `CHT_NEVER(a_count_range, count_q > fresh_q || fresh_q > Nil)
  `CHT_NEVER(a_refused_found, ov_q && os_q && of_q)
  `CHT_ASSERT(a_full_pool, (free_q == Nil) |-> (count_q == Nil))
  `CHT_ASSERT(a_no_take_in_clear, (state_q == ST_CLEAR) |-> !in_ready_o)
endmodule

@@ src/cht_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module cht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ tb/chained_hash_table_test.sv @@
// Testbench for chained_hash_table: directed rows, then random traffic checked by a table model.
module chained_hash_table_test import cht_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBKT = DefBuckets;
  localparam int unsigned NENT = DefEntries;
  localparam int unsigned NIL  = DefEntries;

  typedef struct packed {
    logic              found;
    logic [ValW-1:0]   data;
    logic              status;
    logic [CountW-1:0] count;
  } result_t;

  typedef struct {
    opcode_e         op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] val;
    bit              typed;
    result_t         res;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        opcode_i = '0;
  logic [KeyW-1:0]   key_i = '0;
  logic [ValW-1:0]   value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              found_o;
  logic [ValW-1:0]   data_o;
  logic              status_o;
  logic [CountW-1:0] count_o;

  chained_hash_table dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  // Table model state
  int unsigned bkt_head [NBKT];
  logic [KeyW-1:0] ent_key [NENT];
  logic [ValW-1:0] ent_val [NENT];
  int unsigned ent_next [NENT];
  int unsigned free_ptr;
  int unsigned live_cnt;

  result_t         pending_results[$];
  logic [KeyW-1:0] inserted_keys[$];
  int unsigned     errors = 0;
  int unsigned     send_idle = 0;
  int unsigned     recv_idle = 0;
  int unsigned     hold_cycles = 0;

  function automatic void table_clear();
    for (int i = 0; i < NBKT; i++) bkt_head[i] = NIL;
    for (int i = 0; i < NENT; i++) begin
      ent_key[i] = '0;
      ent_val[i] = '0;
      ent_next[i] = i + 1;
    end
    free_ptr = 0;
    live_cnt = 0;
  endfunction

  function automatic result_t table_apply(opcode_e op, logic [KeyW-1:0] key,
                                          logic [ValW-1:0] val);
    int unsigned b, cur, prev, steps, tail, e;
    result_t r;
    b = key % NBKT;
    prev = NIL;
    cur = bkt_head[b];
    steps = 0;
    while (cur < NIL && steps < NENT) begin
      if (ent_key[cur] == key) break;
      prev = cur;
      cur = ent_next[cur];
      steps++;
    end
    if (cur >= NIL || steps >= NENT) cur = NIL;
    r = '0;
    r.found = (cur < NIL);
    case (op)
      OP_INSERT: begin
        if (r.found) begin
          ent_val[cur] = val;
          r.data = val;
        end else if (free_ptr >= NIL) begin
          r.status = 1'b1;
        end else begin
          e = free_ptr;
          // append at the chain tail
          tail = NIL;
          cur = bkt_head[b];
          steps = 0;
          while (cur < NIL && steps < NENT) begin
            tail = cur;
            cur = ent_next[cur];
            steps++;
          end
          free_ptr = ent_next[e];
          ent_key[e] = key;
          ent_val[e] = val;
          ent_next[e] = NIL;
          if (tail < NIL) ent_next[tail] = e;
          else bkt_head[b] = e;
          live_cnt++;
          r.data = val;
        end
      end
      OP_REMOVE: begin
        if (r.found) begin
          if (prev < NIL) ent_next[prev] = ent_next[cur];
          else bkt_head[b] = ent_next[cur];
          ent_next[cur] = free_ptr;
          free_ptr = cur;
          if (live_cnt > 0) live_cnt--;
        end
      end
      default: begin
        if (r.found) r.data = ent_val[cur];
      end
    endcase
    r.count = CountW'(live_cnt);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Result side: ready pattern and checking
  always @(posedge clk_i) begin
    result_t w;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(data_o), 64'd0);
      end else begin
        w = pending_results.pop_front();
        if (found_o !== w.found) report_mismatch("found", 64'(found_o), 64'(w.found));
        if (data_o !== w.data) report_mismatch("data", 64'(data_o), 64'(w.data));
        if (status_o !== w.status) report_mismatch("status", 64'(status_o), 64'(w.status));
        if (count_o !== w.count) report_mismatch("count", 64'(count_o), 64'(w.count));
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // One transaction: optional idle gap, offer, wait for accept, then predict.
  task automatic send_op(opcode_e op, logic [KeyW-1:0] key, logic [ValW-1:0] val,
                         bit typed = 1'b0, result_t want = '0);
    result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    key_i <= key;
    value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    r = table_apply(op, key, val);
    pending_results.push_back(typed ? want : r);
    if (op == OP_INSERT && !r.status) inserted_keys.push_back(key);
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    logic [23:0] hi;
    logic [7:0] lo;
    if ($urandom_range(99) < 10) return $urandom;
    if (inserted_keys.size() > 0 && $urandom_range(99) < 40)
      return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
    hi = 24'($urandom_range(5));
    if ($urandom_range(1)) hi = ~hi;
    lo = 8'($urandom_range(15));
    if ($urandom_range(1)) lo = ~lo;
    return {hi, lo};
  endfunction

  function automatic opcode_e pick_op(int unsigned ins_w, int unsigned rem_w);
    int unsigned r;
    r = $urandom_range(99);
    if (r < ins_w) return OP_INSERT;
    if (r < ins_w + rem_w) return OP_REMOVE;
    if (r < 95) return OP_LOOKUP;
    return OP_UNUSED;
  endfunction

  function automatic logic [ValW-1:0] pick_val();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  row_t directed[] = '{
    '{OP_LOOKUP, 32'h0000_0000, 32'h0,         1, '{1'b0, 32'h0, 1'b0, 10'd0}},
    '{OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1, '{1'b0, 32'hFFFF_FFFF, 1'b0, 10'd1}},
    '{OP_INSERT, 32'hFFFF_FFFF, 32'h0,         1, '{1'b0, 32'h0, 1'b0, 10'd2}},
    '{OP_INSERT, 32'h0000_0100, 32'h1234_5678, 0, '0},
    '{OP_INSERT, 32'h0000_0200, 32'hA5A5_A5A5, 0, '0},
    '{OP_LOOKUP, 32'h0000_0100, 32'h0,         0, '0},
    '{OP_INSERT, 32'h0000_0000, 32'h5A5A_5A5A, 1, '{1'b1, 32'h5A5A_5A5A, 1'b0, 10'd4}},
    '{OP_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF, 1, '{1'b1, 32'h5A5A_5A5A, 1'b0, 10'd4}},
    '{OP_REMOVE, 32'h0001_2345, 32'h0,         1, '{1'b0, 32'h0, 1'b0, 10'd4}},
    '{OP_REMOVE, 32'h0000_0100, 32'h0,         1, '{1'b1, 32'h0, 1'b0, 10'd3}},
    '{OP_LOOKUP, 32'h0000_0100, 32'h0,         1, '{1'b0, 32'h0, 1'b0, 10'd3}},
    '{OP_REMOVE, 32'h0000_0000, 32'h0,         1, '{1'b1, 32'h0, 1'b0, 10'd2}},
    '{OP_LOOKUP, 32'h0000_0200, 32'h0,         0, '0},
    '{OP_INSERT, 32'h0000_0100, 32'h0000_0001, 0, '0},
    '{OP_REMOVE, 32'hFFFF_FFFF, 32'h0,         1, '{1'b1, 32'h0, 1'b0, 10'd2}},
    '{OP_LOOKUP, 32'h8000_0000, 32'h0,         0, '0}
  };

  int unsigned idle_modes[4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{23, 23}};

  initial begin
    int unsigned n, waited;
    table_clear();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i])
      send_op(directed[i].op, directed[i].key, directed[i].val,
              directed[i].typed, directed[i].res);

    // mixed traffic under each idle pattern
    for (int m = 0; m < 4; m++) begin
      send_idle = idle_modes[m][0];
      recv_idle = idle_modes[m][1];
      repeat (150) send_op(pick_op(45, 25), pick_key(), pick_val());
    end

    // fill the pool; a long output stall backs the block up on the way
    send_idle = 0;
    recv_idle = 10;
    hold_cycles = 400;
    n = 0;
    while (live_cnt < NENT) begin
      send_op(OP_INSERT, {24'(n + 7), 8'(n * 37)}, pick_val());
      n++;
    end
    repeat (10) send_op(OP_INSERT, $urandom, pick_val());
    repeat (10) send_op(pick_op(50, 30), pick_key(), pick_val());

    // drain and refill under each idle pattern
    for (int m = 0; m < 4; m++) begin
      send_idle = idle_modes[m][0];
      recv_idle = idle_modes[m][1];
      repeat (120) send_op(pick_op(30, 50), pick_key(), pick_val());
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      repeat (50) @(posedge clk_i);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
    end
  end
endmodule

@@ files.f @@
+incdir+src
src/cht_pkg.sv
src/cht_ram.sv
src/chained_hash_table.sv
tb/chained_hash_table_test.sv
